>>> hdl/jlgc_pkg.sv
// ----------------------------------------------------------------------------
// jlgc_pkg
// Shared constants for the joystick lamp gesture controller: register
// indexes, reset values, fixed-point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package jlgc_pkg;

  localparam int ANIM_COUNT_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_RATE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MASK = 3'd6;

  localparam logic [14:0] DEADZONE_RST  = 15'd4915;
  localparam logic [14:0] RELEASE_RST   = 15'd3277;
  localparam logic [15:0] LONG_MS_RST   = 16'd500;
  localparam logic [15:0] GAIN_RST      = 16'd2560;
  localparam logic [15:0] INT_RATE_RST  = 16'd16777;
  localparam logic [15:0] HUE_RATE_RST  = 16'd6554;
  localparam logic [7:0]  LOCK_MASK_RST = 8'd0;

  // Hue in Q9.16 degrees, kept below 360 << 16
  localparam int          HUE_W       = 25;
  localparam logic [24:0] HUE_FULL    = 25'd23592960;
  localparam logic [15:0] HUE_NOW_MAX = 16'd46079;

  localparam logic [23:0] LEVEL_MAX = 24'hFFFFFF;
  localparam logic [15:0] RESP_ONE  = 16'h8000;

endpackage

`default_nettype wire

>>> hdl/joystick_lamp_gesture_control.sv
// ----------------------------------------------------------------------------
// joystick_lamp_gesture_control
// Stick Y ramps a lamp intensity through a deadzone response; stick X runs a
// gesture machine that steps the animation or rotates its hue, held in RAM.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid/in_ready   | in_stick_x, in_stick_y, in_elapsed_ms
//  out     | out_valid/out_ready | out_intensity, out_anim_index,
//          |                     | out_hue_now, out_gesture_engaged
//  cfg     | cfg_we              | cfg_index, cfg_wdata
//
//  An item runs through these steps in order: gesture update and RAM read,
//  the two products, the intensity product with the hue read-modify-write,
//  then the result. A new item is taken in the cycle the result is loaded,
//  so the block takes no new item while one is still in its steps.
//  A held result stalls the last step only; the output register frees it.
//  Reset (rst_n low, synchronous) clears state and hue valid bits; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_lamp_gesture_control #(
  parameter int ANIM_COUNT = jlgc_pkg::ANIM_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [15:0]              in_stick_x,
  input  wire logic signed [15:0]              in_stick_y,
  input  wire logic        [7:0]               in_elapsed_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic             [15:0]              out_intensity,
  output logic             [2:0]               out_anim_index,
  output logic             [15:0]              out_hue_now,
  output logic                                 out_gesture_engaged,
  input  wire logic                            cfg_we,
  input  wire logic [jlgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jlgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(ANIM_COUNT);
  localparam int HW = jlgc_pkg::HUE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration
  logic [14:0] deadzone_r, release_r;
  logic [15:0] long_ms_r, gain_r, int_rate_r, hue_rate_r;
  logic [7:0]  lock_mask_r;

  // control state
  logic [2:0]          state_r, state_nxt;
  logic                eng_r, dir_r;
  logic [31:0]         held_r;
  logic [AW-1:0]       anim_r, anim_nxt;
  logic [ANIM_COUNT-1:0] hue_vld_r;
  logic                out_valid_r;

  // item payload
  logic [15:0] x_r, y_r;
  logic [7:0]  dt_r;
  logic [15:0] resp_r;
  logic [7:0]  hdiff_r;
  logic        rot_r;
  logic [31:0] prod_r;
  logic [23:0] step_r;
  logic [24:0] delta_r;
  logic [HW-1:0] hue_res_r;
  logic [23:0] level_r;
  logic [15:0] out_int_r, out_hue_r;
  logic [2:0]  out_anim_r;
  logic        out_eng_r;

  logic        accept, fin_go;

  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || fin_go;
  assign accept   = in_valid && in_ready;

  // ------------------------------------------------------------------
  // Configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= jlgc_pkg::DEADZONE_RST;
      release_r   <= jlgc_pkg::RELEASE_RST;
      long_ms_r   <= jlgc_pkg::LONG_MS_RST;
      gain_r      <= jlgc_pkg::GAIN_RST;
      int_rate_r  <= jlgc_pkg::INT_RATE_RST;
      hue_rate_r  <= jlgc_pkg::HUE_RATE_RST;
      lock_mask_r <= jlgc_pkg::LOCK_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jlgc_pkg::CFG_DEADZONE:  deadzone_r  <= cfg_wdata[14:0];
        jlgc_pkg::CFG_RELEASE:   release_r   <= cfg_wdata[14:0];
        jlgc_pkg::CFG_LONG_MS:   long_ms_r   <= cfg_wdata;
        jlgc_pkg::CFG_GAIN:      gain_r      <= cfg_wdata;
        jlgc_pkg::CFG_INT_RATE:  int_rate_r  <= cfg_wdata;
        jlgc_pkg::CFG_HUE_RATE:  hue_rate_r  <= cfg_wdata;
        jlgc_pkg::CFG_LOCK_MASK: lock_mask_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Gesture and response (ST_CALC)
  // ------------------------------------------------------------------
  logic [16:0] mx, my, ydiff;
  logic [32:0] rprod;
  logic [21:0] rshift;
  logic [15:0] resp;
  logic        engage, release_hit, hold, short_press, locked, rot;
  logic [32:0] held_sum;
  logic [31:0] held_new, held_from, held_span;
  logic [AW+2:0] anim_wide;

  assign mx = x_r[15] ? (17'd0 - {x_r[15], x_r}) : {1'b0, x_r};
  assign my = y_r[15] ? (17'd0 - {y_r[15], y_r}) : {1'b0, y_r};

  assign ydiff  = my - {2'b00, deadzone_r};
  assign rprod  = 33'(ydiff) * 33'(gain_r);
  assign rshift = rprod[32:11];
  always_comb begin
    if (my < {2'b00, deadzone_r}) begin
      resp = '0;
    end else if (rshift > 22'(jlgc_pkg::RESP_ONE)) begin
      resp = jlgc_pkg::RESP_ONE;
    end else begin
      resp = rshift[15:0];
    end
  end

  assign engage      = !eng_r && (mx >= {2'b00, deadzone_r});
  assign release_hit = eng_r && (mx < {2'b00, release_r});
  assign hold        = eng_r && !release_hit;
  assign short_press = held_r < {16'd0, long_ms_r};

  assign held_sum  = {1'b0, held_r} + 33'(dt_r);
  assign held_new  = held_sum[32] ? '1 : held_sum[31:0];
  assign held_from = (held_r > {16'd0, long_ms_r}) ? held_r : {16'd0, long_ms_r};
  assign held_span = held_new - held_from;

  // animations numbered 8 and up have no lock bit
  assign anim_wide = (AW+3)'(anim_r);
  assign locked    = (anim_wide[AW+2:3] == '0) && lock_mask_r[anim_wide[2:0]];
  assign rot       = hold && (held_new > {16'd0, long_ms_r}) && !locked;

  always_comb begin
    anim_nxt = anim_r;
    if (release_hit && short_press) begin
      if (!dir_r) begin
        anim_nxt = (anim_r == AW'(ANIM_COUNT-1)) ? '0 : anim_r + AW'(1);
      end else begin
        anim_nxt = (anim_r == '0) ? AW'(ANIM_COUNT-1) : anim_r - AW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Hue table RAM: read at the selected animation, write back on rotation
  // ------------------------------------------------------------------
  logic [AW-1:0] ram_raddr;
  logic [HW-1:0] ram_rdata, hue_old, hue_new;
  logic [HW:0]   hue_sum;
  logic          hue_we;

  assign ram_raddr = (state_r == ST_CALC) ? anim_nxt : anim_r;
  assign hue_old   = hue_vld_r[anim_r] ? ram_rdata : '0;
  assign hue_sum   = {1'b0, hue_old} + (HW+1)'(step_r);

  always_comb begin
    if (!dir_r) begin
      hue_new = (hue_sum >= {1'b0, jlgc_pkg::HUE_FULL}) ?
                HW'(hue_sum - {1'b0, jlgc_pkg::HUE_FULL}) : hue_sum[HW-1:0];
    end else if (HW'(step_r) <= hue_old) begin
      hue_new = hue_old - HW'(step_r);
    end else begin
      hue_new = hue_old + (jlgc_pkg::HUE_FULL - HW'(step_r));
    end
  end

  assign hue_we = (state_r == ST_STEP) && rot_r;

  jlgc_ram #(
    .WIDTH (HW),
    .DEPTH (ANIM_COUNT)
  ) u_hue_ram (
    .clk   (clk),
    .we    (hue_we),
    .waddr (anim_r),
    .wdata (hue_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Intensity accumulate (ST_FIN)
  // ------------------------------------------------------------------
  logic [39:0] dprod;
  logic [25:0] lvl_sum;
  logic [23:0] level_nxt;

  assign dprod   = 40'(prod_r) * 40'(dt_r);
  assign lvl_sum = 26'(level_r) + 26'(delta_r);

  always_comb begin
    if (y_r[15]) begin
      level_nxt = (delta_r >= 25'(level_r)) ? '0 : level_r - delta_r[23:0];
    end else begin
      level_nxt = (lvl_sum > 26'(jlgc_pkg::LEVEL_MAX)) ? jlgc_pkg::LEVEL_MAX
                                                        : lvl_sum[23:0];
    end
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = accept ? ST_CALC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eng_r       <= 1'b0;
      dir_r       <= 1'b0;
      held_r      <= '0;
      anim_r      <= '0;
      hue_vld_r   <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC) begin
        anim_r <= anim_nxt;
        if (engage) begin
          eng_r  <= 1'b1;
          dir_r  <= !(!x_r[15] && (x_r != '0));
          held_r <= '0;
        end else if (release_hit) begin
          eng_r <= 1'b0;
        end else if (hold) begin
          held_r <= held_new;
        end
      end
      if (hue_we) begin
        hue_vld_r[anim_r] <= 1'b1;
      end
      if (fin_go) begin
        level_r     <= level_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r  <= in_stick_x;
      y_r  <= in_stick_y;
      dt_r <= in_elapsed_ms;
    end
    if (state_r == ST_CALC) begin
      resp_r  <= resp;
      hdiff_r <= held_span[7:0];
      rot_r   <= rot;
    end
    if (state_r == ST_MUL) begin
      prod_r <= 32'(resp_r) * 32'(int_rate_r);
      step_r <= 24'(hdiff_r) * 24'(hue_rate_r);
    end
    if (state_r == ST_STEP) begin
      delta_r   <= dprod[39:15];
      hue_res_r <= rot_r ? hue_new : hue_old;
    end
    if (fin_go) begin
      out_int_r  <= level_nxt[23:8];
      out_anim_r <= anim_wide[2:0];
      out_hue_r  <= hue_res_r[HW-1:9];
      out_eng_r  <= eng_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_intensity       = out_int_r;
  assign out_anim_index      = out_anim_r;
  assign out_hue_now         = out_hue_r;
  assign out_gesture_engaged = out_eng_r;

endmodule

`default_nettype wire

>>> hdl/jlgc_ram.sv
// ----------------------------------------------------------------------------
// jlgc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jlgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/jlgc_chk.sv
// ----------------------------------------------------------------------------
// jlgc_chk
// Port-level checks for the joystick lamp gesture controller, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jlgc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_intensity,
  input wire logic [2:0]  out_anim_index,
  input wire logic [15:0] out_hue_now,
  input wire logic        out_gesture_engaged
);

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_intensity) &&
      $stable(out_anim_index) && $stable(out_hue_now) && $stable(out_gesture_engaged))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the block is busy after each transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_now <= jlgc_pkg::HUE_NOW_MAX)
    else $error("hue beyond 360 degrees");

endmodule

bind joystick_lamp_gesture_control jlgc_chk u_jlgc_chk (.*);

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the joystick lamp gesture controller against a cycle-free predictor
// of intensity ramping, animation stepping and hue rotation. Directed samples
// come first, then random gesture sequences over several register settings,
// with idle and stall phases on the stick and result channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          SETTLE_CYCLES = 10;
  localparam logic [2:0]  CFG_UNUSED    = 3'd7;

  typedef struct packed {
    logic [15:0] stick_x;
    logic [15:0] stick_y;
    logic [7:0]  elapsed_ms;
  } stick_in_t;

  typedef struct packed {
    logic [15:0] intensity;
    logic [2:0]  anim_index;
    logic [15:0] hue_now;
    logic        engaged;
  } lamp_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_stick_x = '0;
  logic signed [15:0] in_stick_y = '0;
  logic        [7:0]  in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [15:0] out_intensity;
  logic        [2:0]  out_anim_index;
  logic        [15:0] out_hue_now;
  logic               out_gesture_engaged;
  logic               cfg_we = 1'b0;
  logic [jlgc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jlgc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies used by the predictor
  logic [14:0] dz_cfg        = jlgc_pkg::DEADZONE_RST;
  logic [14:0] release_cfg   = jlgc_pkg::RELEASE_RST;
  logic [15:0] long_ms_cfg   = jlgc_pkg::LONG_MS_RST;
  logic [15:0] gain_cfg      = jlgc_pkg::GAIN_RST;
  logic [15:0] level_rate_cfg = jlgc_pkg::INT_RATE_RST;
  logic [15:0] hue_rate_cfg  = jlgc_pkg::HUE_RATE_RST;
  logic [7:0]  lock_cfg      = jlgc_pkg::LOCK_MASK_RST;

  // Predicted lamp state
  logic [23:0] level_q     = '0;
  logic        engaged_q   = 1'b0;
  logic        push_left_q = 1'b0;
  logic [31:0] held_q      = '0;
  logic [2:0]  anim_q      = '0;
  logic [24:0] hue_mem [0:jlgc_pkg::ANIM_COUNT_DEF-1];

  stick_in_t pending_sticks[$];
  lamp_out_t expected_lamp[$];

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic in_fire        = 1'b0;

  joystick_lamp_gesture_control DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stick_x          (in_stick_x),
    .in_stick_y          (in_stick_y),
    .in_elapsed_ms       (in_elapsed_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_intensity       (out_intensity),
    .out_anim_index      (out_anim_index),
    .out_hue_now         (out_hue_now),
    .out_gesture_engaged (out_gesture_engaged),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < jlgc_pkg::ANIM_COUNT_DEF; i++) hue_mem[i] = '0;
  end

  // Advance the lamp state by one stick sample and return the new outputs
  function automatic lamp_out_t step_lamp(input stick_in_t s);
    logic [16:0] mag_x;
    logic [16:0] mag_y;
    logic [63:0] resp;
    logic [63:0] delta;
    logic [63:0] level_sum;
    logic [63:0] turn;
    logic [63:0] hue_acc;
    logic [32:0] held_sum;
    logic [31:0] held_prev;
    logic [31:0] hold_from;
    lamp_out_t   o;
    mag_x = s.stick_x[15] ? (17'd0 - {s.stick_x[15], s.stick_x}) : {1'b0, s.stick_x};
    mag_y = s.stick_y[15] ? (17'd0 - {s.stick_y[15], s.stick_y}) : {1'b0, s.stick_y};

    if (mag_y < dz_cfg) begin
      resp = '0;
    end else begin
      resp = ((mag_y - dz_cfg) * gain_cfg) >> 11;
      if (resp > jlgc_pkg::RESP_ONE) resp = 64'(jlgc_pkg::RESP_ONE);
    end
    delta = (resp * level_rate_cfg * s.elapsed_ms) >> 15;
    if (s.stick_y[15]) begin
      level_q = (delta >= level_q) ? 24'd0 : level_q - delta[23:0];
    end else begin
      level_sum = delta + level_q;
      level_q = (level_sum > jlgc_pkg::LEVEL_MAX) ? jlgc_pkg::LEVEL_MAX : level_sum[23:0];
    end

    if (!engaged_q) begin
      if (mag_x >= dz_cfg) begin
        engaged_q   = 1'b1;
        // zero deflection counts as a left push
        push_left_q = s.stick_x[15] || (s.stick_x == 16'd0);
        held_q      = '0;
      end
    end else if (mag_x < release_cfg) begin
      if (held_q < long_ms_cfg) anim_q = push_left_q ? anim_q - 3'd1 : anim_q + 3'd1;
      engaged_q = 1'b0;
    end else begin
      held_prev = held_q;
      held_sum  = {1'b0, held_q} + 33'(s.elapsed_ms);
      held_q    = held_sum[32] ? 32'hFFFF_FFFF : held_sum[31:0];
      if (held_q > long_ms_cfg && !lock_cfg[anim_q]) begin
        hold_from = (held_prev > long_ms_cfg) ? held_prev : {16'd0, long_ms_cfg};
        turn      = ((held_q - hold_from) * hue_rate_cfg) % jlgc_pkg::HUE_FULL;
        hue_acc   = push_left_q ? hue_mem[anim_q] + jlgc_pkg::HUE_FULL - turn
                                : hue_mem[anim_q] + turn;
        hue_acc   = hue_acc % jlgc_pkg::HUE_FULL;
        hue_mem[anim_q] = hue_acc[24:0];
      end
    end

    o.intensity  = level_q[23:8];
    o.anim_index = anim_q;
    o.hue_now    = hue_mem[anim_q][24:9];
    o.engaged    = engaged_q;
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on each accepted sample, check each accepted result
  always @(posedge clk) begin : monitor
    lamp_out_t want;
    if (rst_n && in_valid && in_ready) begin
      expected_lamp.push_back(step_lamp({in_stick_x, in_stick_y, in_elapsed_ms}));
      in_fire = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_lamp.size() == 0) begin
        $display("%0t: result with nothing expected, actual intensity %0d anim %0d",
                 $time, out_intensity, out_anim_index);
        mismatch_count++;
      end else begin
        want = expected_lamp.pop_front();
        compare_field("intensity", want.intensity, out_intensity);
        compare_field("anim_index", {13'd0, want.anim_index}, {13'd0, out_anim_index});
        compare_field("hue_now", want.hue_now, out_hue_now);
        compare_field("gesture_engaged", {15'd0, want.engaged}, {15'd0, out_gesture_engaged});
      end
    end
  end

  // Hold valid until the transfer, then maybe idle before the next sample
  always @(negedge clk) begin : driver
    logic      next_valid;
    stick_in_t nxt;
    if (rst_n) begin
      next_valid = in_valid && !in_fire;
      if (!next_valid && pending_sticks.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_sticks.pop_front();
        in_stick_x    <= nxt.stick_x;
        in_stick_y    <= nxt.stick_y;
        in_elapsed_ms <= nxt.elapsed_ms;
        next_valid = 1'b1;
      end
      in_valid  <= next_valid;
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
    in_fire = 1'b0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      jlgc_pkg::CFG_DEADZONE:  dz_cfg         = value[14:0];
      jlgc_pkg::CFG_RELEASE:   release_cfg    = value[14:0];
      jlgc_pkg::CFG_LONG_MS:   long_ms_cfg    = value;
      jlgc_pkg::CFG_GAIN:      gain_cfg       = value;
      jlgc_pkg::CFG_INT_RATE:  level_rate_cfg = value;
      jlgc_pkg::CFG_HUE_RATE:  hue_rate_cfg   = value;
      jlgc_pkg::CFG_LOCK_MASK: lock_cfg       = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_stick(input logic [15:0] x, input logic [15:0] y,
                             input logic [7:0] dt);
    stick_in_t s;
    s.stick_x    = x;
    s.stick_y    = y;
    s.elapsed_ms = dt;
    pending_sticks.push_back(s);
  endtask

  task automatic wait_drained();
    while (!(pending_sticks.size() == 0 && !in_valid && expected_lamp.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] x_from_mag(input logic [16:0] mag);
    logic [16:0] neg;
    neg = 17'd0 - mag;
    return ($urandom_range(1) == 1) ? neg[15:0] : mag[15:0];
  endfunction

  function automatic logic [15:0] rand_y();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] rand_dt();
    case ($urandom_range(3))
      0: return 8'($urandom_range(8));
      1: return 8'($urandom_range(60));
      2: return 8'($urandom_range(255));
      default: return 8'd255;
    endcase
  endfunction

  // Mostly well-formed engage / hold / release runs, some raw noise
  task automatic fill_random(input int count);
    int          made;
    int          holds;
    logic [15:0] x;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) < 8) begin
        holds = $urandom_range(6);
        x = ($urandom_range(7) == 0) ? 16'd0
                                     : x_from_mag(17'($urandom_range(32768, dz_cfg)));
        queue_stick(x, rand_y(), rand_dt());
        repeat (holds)
          queue_stick(x_from_mag(17'($urandom_range(32768, release_cfg))),
                      rand_y(), rand_dt());
        x = (release_cfg == 0) ? 16'($urandom())
                               : x_from_mag(17'($urandom_range(release_cfg - 1, 0)));
        queue_stick(x, rand_y(), rand_dt());
        made += holds + 2;
      end else begin
        queue_stick(16'($urandom()), 16'($urandom()), 8'($urandom()));
        made++;
      end
    end
  endtask

  task automatic apply_settings(input int k);
    case (k)
      0: begin
        write_reg(jlgc_pkg::CFG_DEADZONE, {1'b0, jlgc_pkg::DEADZONE_RST});
        write_reg(jlgc_pkg::CFG_RELEASE, {1'b0, jlgc_pkg::RELEASE_RST});
        write_reg(jlgc_pkg::CFG_LONG_MS, jlgc_pkg::LONG_MS_RST);
        write_reg(jlgc_pkg::CFG_GAIN, jlgc_pkg::GAIN_RST);
        write_reg(jlgc_pkg::CFG_INT_RATE, jlgc_pkg::INT_RATE_RST);
        write_reg(jlgc_pkg::CFG_HUE_RATE, jlgc_pkg::HUE_RATE_RST);
        write_reg(jlgc_pkg::CFG_LOCK_MASK, {8'd0, jlgc_pkg::LOCK_MASK_RST});
      end
      1: begin
        // all ones: top bits above each register width must drop
        write_reg(jlgc_pkg::CFG_DEADZONE, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_RELEASE, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_LONG_MS, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_GAIN, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_INT_RATE, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_HUE_RATE, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_LOCK_MASK, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'($urandom()));
      end
      2: begin
        write_reg(jlgc_pkg::CFG_DEADZONE, 16'd0);
        write_reg(jlgc_pkg::CFG_RELEASE, 16'd0);
        write_reg(jlgc_pkg::CFG_LONG_MS, 16'd0);
        write_reg(jlgc_pkg::CFG_GAIN, 16'd0);
        write_reg(jlgc_pkg::CFG_INT_RATE, 16'd0);
        write_reg(jlgc_pkg::CFG_HUE_RATE, 16'd0);
        write_reg(jlgc_pkg::CFG_LOCK_MASK, 16'd0);
      end
      3: begin
        write_reg(jlgc_pkg::CFG_DEADZONE, 16'd0);
        write_reg(jlgc_pkg::CFG_RELEASE, 16'd2000);
        write_reg(jlgc_pkg::CFG_GAIN, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_INT_RATE, 16'hFFFF);
        write_reg(jlgc_pkg::CFG_HUE_RATE, 16'hFFFF);
      end
      4: begin
        write_reg(jlgc_pkg::CFG_DEADZONE, 16'd8000);
        write_reg(jlgc_pkg::CFG_RELEASE, 16'd6000);
        write_reg(jlgc_pkg::CFG_LONG_MS, 16'd30);
        write_reg(jlgc_pkg::CFG_GAIN, 16'd4096);
        write_reg(jlgc_pkg::CFG_INT_RATE, 16'd3000);
        write_reg(jlgc_pkg::CFG_LOCK_MASK, 16'h005A);
      end
      default: begin
        write_reg(jlgc_pkg::CFG_DEADZONE,
                  16'($urandom_range(16000) | ($urandom_range(1) << 15)));
        write_reg(jlgc_pkg::CFG_RELEASE, 16'($urandom_range(dz_cfg)));
        write_reg(jlgc_pkg::CFG_LONG_MS, 16'($urandom_range(1000)));
        write_reg(jlgc_pkg::CFG_GAIN, 16'($urandom()));
        write_reg(jlgc_pkg::CFG_INT_RATE, 16'($urandom()));
        write_reg(jlgc_pkg::CFG_HUE_RATE, 16'($urandom()));
        write_reg(jlgc_pkg::CFG_LOCK_MASK, 16'($urandom()));
      end
    endcase
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed run at reset settings
    queue_stick(16'd0, 16'd0, 8'd0);
    queue_stick(16'sd32767, 16'sd32767, 8'd255);   // engage right, ramp up
    queue_stick(16'sd20000, 16'sd32767, 8'd255);
    queue_stick(16'sd20000, 16'sd32767, 8'd255);   // past long press, hue turns
    queue_stick(16'd0, 16'sd32767, 8'd255);        // release after long hold, saturate
    queue_stick(16'd0, 16'sd4914, 8'd255);         // just below deadzone
    queue_stick(-16'sd32768, 16'sd4915, 8'd7);     // engage left, response exactly zero
    queue_stick(-16'sd3277, -16'sd32768, 8'd255);  // hold at release level
    queue_stick(16'sd3276, -16'sd32768, 8'd255);   // short press left wraps to top
    queue_stick(-16'sd4915, -16'sd32768, 8'd255);  // engage at deadzone
    queue_stick(-16'sd32768, -16'sd32768, 8'd255);
    queue_stick(-16'sd32768, -16'sd20000, 8'd250); // hue turns negative, wraps
    queue_stick(16'sd100, 16'd0, 8'd0);
    queue_stick(16'sd4915, 16'd0, 8'd0);
    queue_stick(-16'sd100, 16'd0, 8'd1);           // short press right wraps to zero
    queue_stick(16'sd32767, 16'd0, 8'd0);
    queue_stick(16'sd32767, 16'd0, 8'd250);
    queue_stick(16'sd32767, 16'd0, 8'd250);        // held equals long press
    queue_stick(16'd0, 16'd0, 8'd0);               // neither step nor turn
    queue_stick(-16'sd1, -16'sd1, 8'd1);
    queue_stick(16'sd1, 16'sd1, 8'd1);
    queue_stick(-16'sd32768, -16'sd32768, 8'd0);
    queue_stick(16'sd32767, 16'sd32767, 8'd0);
    queue_stick(16'd0, 16'd0, 8'd255);
    wait_drained();

    for (int k = 0; k < 8; k++) begin
      apply_settings(k);
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // pause the sender midway until every result is back
      fill_random(47);
      wait_drained();
      fill_random(47);
      wait_drained();
    end

    if (mismatch_count == 0 && expected_lamp.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
